FILE: rtl/mbd_pkg.sv
package mbd_pkg;

   // Default for the widest source row the line store must hold.
   localparam int MAX_SOURCE_WIDTH_DEF = 4096;
   // Tallest source level.
   localparam int HEIGHT_LIMIT = 4096;
   // Widest value the 13-bit width register can hold.
   localparam int DIM_MAX = 8191;

   localparam int DIM_W   = 13;          // width / height registers
   localparam int COL_W   = 13;          // column counter
   localparam int ROW_W   = 12;          // row counter
   localparam int XO_W    = COL_W - 1;   // output column
   localparam int YO_W    = ROW_W - 1;   // output row
   localparam int CHAN_W  = 8;
   localparam int LANES   = 4;
   localparam int SUM_W   = CHAN_W + 1;  // horizontal pair sum of one channel
   localparam int PAIR_W  = SUM_W * LANES;
   localparam int SHIFT_W = 2;

   // CSR indexes
   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MODE   = 2'd2;
   localparam int CSR_IDX_W = 2;

   // channel modes
   localparam logic [1:0] MODE_FOUR = 2'd0;
   localparam logic [1:0] MODE_TWO  = 2'd1;
   localparam logic [1:0] MODE_ONE  = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] chan_a;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_c;
      logic [CHAN_W-1:0] chan_d;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] avg_a;
      logic [CHAN_W-1:0] avg_b;
      logic [CHAN_W-1:0] avg_c;
      logic [CHAN_W-1:0] avg_d;
      logic              level_done;
   } rsp_type;

   // Per-pixel decode from the position tracker.
   typedef struct packed {
      logic              w_one;      // source width is 1
      logic              h_one;      // source height is 1
      logic              load_pair;  // even column: park pixel in pair register
      logic              emit;       // this pixel completes an output block
      logic              store_wr;   // even row: write pair sum to line store
      logic [XO_W-1:0]   xo;
      logic [SHIFT_W-1:0] shift;
      logic              last;
   } dec_type;

   // Control held alongside a block in the first stage.
   typedef struct packed {
      logic               h_one;
      logic [SHIFT_W-1:0] shift;
      logic               last;
      logic [LANES-1:0]   active;
   } s1_ctl_type;

   function automatic logic [LANES-1:0] active_mask(input logic [1:0] mode);
      logic [LANES-1:0] m;
      unique case (mode)
         MODE_FOUR: m = 4'b1111;
         MODE_TWO:  m = 4'b0011;
         default:   m = 4'b0001;   // one channel, unused code too
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/mbd_pos.sv
module mbd_pos #(
   parameter int MAX_SOURCE_WIDTH = mbd_pkg::MAX_SOURCE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        restart,
   input  logic                        accept,
   input  logic [mbd_pkg::DIM_W-1:0]   source_width,
   input  logic [mbd_pkg::DIM_W-1:0]   source_height,
   output mbd_pkg::dec_type            dec
);

   localparam int WLIM = (MAX_SOURCE_WIDTH > mbd_pkg::DIM_MAX) ?
                         mbd_pkg::DIM_MAX : MAX_SOURCE_WIDTH;

   logic [mbd_pkg::COL_W-1:0] col_ff, col_in;
   logic [mbd_pkg::ROW_W-1:0] row_ff, row_in;
   logic [mbd_pkg::DIM_W-1:0] w, h;
   logic [mbd_pkg::XO_W-1:0]  wd, xo;
   logic [mbd_pkg::ROW_W-1:0] hd;
   logic [mbd_pkg::YO_W-1:0]  yo;
   logic                      w_one, h_one, in_cols, in_rows, have_pair;

   always_comb begin
      // zero counts as one, oversize is clamped
      if (source_width == '0) begin
         w = mbd_pkg::DIM_W'(1);
      end else if (source_width > mbd_pkg::DIM_W'(WLIM)) begin
         w = mbd_pkg::DIM_W'(WLIM);
      end else begin
         w = source_width;
      end
      if (source_height == '0) begin
         h = mbd_pkg::DIM_W'(1);
      end else if (source_height > mbd_pkg::DIM_W'(mbd_pkg::HEIGHT_LIMIT)) begin
         h = mbd_pkg::DIM_W'(mbd_pkg::HEIGHT_LIMIT);
      end else begin
         h = source_height;
      end

      w_one = (w == mbd_pkg::DIM_W'(1));
      h_one = (h == mbd_pkg::DIM_W'(1));
      wd    = w_one ? mbd_pkg::XO_W'(1) : w[mbd_pkg::DIM_W-1:1];
      hd    = h_one ? mbd_pkg::ROW_W'(1) : h[mbd_pkg::DIM_W-1:1];

      in_cols   = col_ff < {wd, 1'b0};
      in_rows   = {1'b0, row_ff} < {hd, 1'b0};
      have_pair = w_one || (in_cols && col_ff[0]);
      xo        = w_one ? '0 : col_ff[mbd_pkg::COL_W-1:1];
      yo        = h_one ? '0 : row_ff[mbd_pkg::ROW_W-1:1];

      dec.w_one     = w_one;
      dec.h_one     = h_one;
      dec.load_pair = !w_one && in_cols && !col_ff[0];
      dec.emit      = have_pair && in_rows && (h_one || row_ff[0]);
      dec.store_wr  = have_pair && in_rows && !h_one && !row_ff[0];
      dec.xo        = xo;
      dec.shift     = {1'b0, !w_one} + {1'b0, !h_one};
      dec.last      = (xo == wd - mbd_pkg::XO_W'(1)) &&
                      ({1'b0, yo} == hd - mbd_pkg::ROW_W'(1));

      // raster walk, wraps to the origin after the last pixel
      col_in = col_ff;
      row_in = row_ff;
      if ({1'b0, col_ff} + (mbd_pkg::COL_W+1)'(1) >= {1'b0, w}) begin
         col_in = '0;
         if ({1'b0, row_ff} + (mbd_pkg::ROW_W+1)'(1) >= h) begin
            row_in = '0;
         end else begin
            row_in = row_ff + mbd_pkg::ROW_W'(1);
         end
      end else begin
         col_in = col_ff + mbd_pkg::COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

FILE: rtl/mbd_lane.sv
module mbd_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic                          accept,
   input  mbd_pkg::dec_type              dec,
   input  logic                          lane_on,
   input  logic [mbd_pkg::CHAN_W-1:0]    pix,
   input  logic [mbd_pkg::SUM_W-1:0]     prev,
   input  mbd_pkg::s1_ctl_type           s1_ctl,
   input  logic                          s1_lane_on,
   output logic [mbd_pkg::SUM_W-1:0]     hpair,
   output logic [mbd_pkg::CHAN_W-1:0]    avg
);

   logic [mbd_pkg::SUM_W-1:0] pair_ff;
   logic [mbd_pkg::SUM_W-1:0] hp_ff;
   logic [mbd_pkg::SUM_W-1:0] pix9;
   logic [mbd_pkg::SUM_W:0]   total;
   logic [mbd_pkg::SUM_W:0]   scaled;

   always_comb begin
      pix9  = lane_on ? {1'b0, pix} : '0;
      hpair = dec.w_one ? pix9 : pair_ff + pix9;

      // vertical add and box divide
      total  = (s1_ctl.h_one ? '0 : {1'b0, prev}) + {1'b0, hp_ff};
      scaled = total >> s1_ctl.shift;
      avg    = s1_lane_on ? scaled[mbd_pkg::CHAN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         pair_ff <= '0;
      end else if (accept && dec.load_pair) begin
         pair_ff <= pix9;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && dec.emit) begin
         hp_ff <= hpair;
      end
   end

endmodule

FILE: rtl/mip_box_downsample.sv
// 2x2 box-filter mip downsampler. Source pixels (up to four 8-bit channels)
// stream in raster order on the req_ channel, one request per clock when
// rsp_ is not stalling. Each output pixel is the truncating average of its
// 2x2 source block; it is held in stage 1, then in the output register, and
// leaves on rsp_ from there; level_done marks the last pixel of the level. The
// output level is max(1, W/2) x max(1, H/2); an odd last row or column is
// dropped, and a dimension of 1 averages over one sample in that direction.
// Four lanes (one per channel) form horizontal pair sums; pair sums of even
// rows are parked in a line store of MAX_SOURCE_WIDTH/2 entries, read back on
// the odd row. The store has a single write and a single registered read
// port, hence two stages; throughput is one pixel per clock unless rsp_ stalls.
// Program source_width (0), source_height (1) and channel_mode (2: 0 four,
// 1 two, 2 one channel) while idle; any such write restarts the level at the
// top-left pixel. Unused output channels read zero.
module mip_box_downsample #(
   parameter int MAX_SOURCE_WIDTH = mbd_pkg::MAX_SOURCE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  mbd_pkg::req_type                 req_data,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output mbd_pkg::rsp_type                 rsp_data,

   input  logic                             csr_write,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbd_pkg::DIM_W-1:0]        csr_data
);

   localparam int STORE_DEPTH = MAX_SOURCE_WIDTH / 2;
   localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // config registers
   logic [mbd_pkg::DIM_W-1:0] width_ff, height_ff;
   logic [1:0]                mode_ff;
   logic                      restart;

   // handshake
   logic advance, accept;

   // stage 1: horizontal sums held in the lanes, vertical partner in rd_ff
   logic                         s1_valid_ff, s1_valid_in;
   mbd_pkg::s1_ctl_type          s1_ctl_ff;
   logic [mbd_pkg::PAIR_W-1:0]   rd_ff;

   // stage 2: output register
   logic                         out_valid_ff, out_valid_in;
   mbd_pkg::rsp_type             out_ff;

   mbd_pkg::dec_type             dec;
   logic [mbd_pkg::LANES-1:0]    active;
   logic [mbd_pkg::CHAN_W-1:0]   pix  [mbd_pkg::LANES];
   logic [mbd_pkg::SUM_W-1:0]    hpair[mbd_pkg::LANES];
   logic [mbd_pkg::CHAN_W-1:0]   avg  [mbd_pkg::LANES];
   logic [mbd_pkg::PAIR_W-1:0]   pair_word;
   logic [AW-1:0]                addr;

   // line store: pair sums of the even source row
   logic [mbd_pkg::PAIR_W-1:0]   store_mem [STORE_DEPTH];

   //-------------------------------------------------------------------------
   // CSR writes; a write to any defined register restarts the level
   //-------------------------------------------------------------------------
   always_comb begin
      restart = csr_write && (csr_index == mbd_pkg::CSR_WIDTH ||
                              csr_index == mbd_pkg::CSR_HEIGHT ||
                              csr_index == mbd_pkg::CSR_MODE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbd_pkg::DIM_W'(1);
         height_ff <= mbd_pkg::DIM_W'(1);
         mode_ff   <= mbd_pkg::MODE_FOUR;
      end else if (csr_write) begin
         unique case (csr_index)
            mbd_pkg::CSR_WIDTH:  width_ff  <= csr_data;
            mbd_pkg::CSR_HEIGHT: height_ff <= csr_data;
            mbd_pkg::CSR_MODE:   mode_ff   <= csr_data[1:0];
            default: ;           // undefined index, ignored
         endcase
      end
   end

   //-------------------------------------------------------------------------
   // Flow control: stage 1 drains whenever the output register is free or
   // being taken, so a request can enter every clock unless rsp_ stalls.
   //-------------------------------------------------------------------------
   always_comb begin
      advance   = !out_valid_ff || !rsp_stall;
      req_stall = s1_valid_ff && !advance;
      accept    = req_valid && !req_stall;
      active    = mbd_pkg::active_mask(mode_ff);

      pix[0] = req_data.chan_a;
      pix[1] = req_data.chan_b;
      pix[2] = req_data.chan_c;
      pix[3] = req_data.chan_d;

      // only pixels that finish a block travel down the pipe
      if (accept) begin
         s1_valid_in = dec.emit;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;

      addr = AW'(dec.xo);
   end

   mbd_pos #(
      .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
   ) u_pos (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .accept        (accept),
      .source_width  (width_ff),
      .source_height (height_ff),
      .dec           (dec)
   );

   //-------------------------------------------------------------------------
   // Channel lanes
   //-------------------------------------------------------------------------
   for (genvar i = 0; i < mbd_pkg::LANES; i++) begin : g_lane
      mbd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .restart    (restart),
         .accept     (accept),
         .dec        (dec),
         .lane_on    (active[i]),
         .pix        (pix[i]),
         .prev       (rd_ff[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]),
         .s1_ctl     (s1_ctl_ff),
         .s1_lane_on (s1_ctl_ff.active[i]),
         .hpair      (hpair[i]),
         .avg        (avg[i])
      );
      assign pair_word[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] = hpair[i];
   end

   //-------------------------------------------------------------------------
   // Line store: write on even rows, registered read on every request. The
   // odd-row read of an entry always follows its write by a full row.
   //-------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && dec.store_wr) begin
         store_mem[addr] <= pair_word;
      end
      if (accept) begin
         rd_ff <= store_mem[addr];
      end
   end

   //-------------------------------------------------------------------------
   // Pipeline registers
   //-------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && dec.emit) begin
         s1_ctl_ff.h_one  <= dec.h_one;
         s1_ctl_ff.shift  <= dec.shift;
         s1_ctl_ff.last   <= dec.last;
         s1_ctl_ff.active <= active;
      end
   end

   // merge: lanes into one result
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_ff.avg_a      <= avg[0];
         out_ff.avg_b      <= avg[1];
         out_ff.avg_c      <= avg[2];
         out_ff.avg_d      <= avg[3];
         out_ff.level_done <= s1_ctl_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

FILE: sim/tb_mip_box_downsample.sv
`timescale 1ns / 100ps

// Self-checking bench for the 2x2 box-filter mip downsampler.
// Source pixels go in as requests on req_, averaged pixels come back on rsp_.
// An in-bench box-average predictor tracks position, the pending pair sum and
// the line of even-row pair sums, and queues the expected averaged pixel for
// every accepted request that completes a block.
module tb_mip_box_downsample;
   import mbd_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
   localparam int RUN_LIMIT_NS = 5_000_000;  // watchdog
   localparam int STORE_DEPTH  = MAX_SOURCE_WIDTH_DEF / 2;

   // Codes the package leaves unnamed: the spare mode and the spare register.
   localparam logic [1:0]           MODE_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_e;

   // One line of the directed table. A row marked given carries the averaged
   // pixel typed in by hand; other pixel rows use the predictor.
   typedef struct packed {
      row_kind_e            kind;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [DIM_W-1:0]     csr_value;
      req_type              px;
      logic                 given;
      rsp_type              result;
   } stim_row_t;

   // DUT ports, all known from time zero
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_data  = '0;

   // Idle rates in percent, changed by the run sequence
   int send_idle_pct = 27;
   int recv_idle_pct = 74;

   // Long hold-off: the sequence toggles hold_kick, the receiver serves it
   logic hold_kick = 1'b0;
   logic hold_ack  = 1'b0;
   int   hold_left = 0;

   // Predictor state: register copies and position within the level
   logic [DIM_W-1:0]  cfg_width  = 13'd1;
   logic [DIM_W-1:0]  cfg_height = 13'd1;
   logic [1:0]        cfg_mode   = MODE_FOUR;
   int unsigned       pos_col    = 0;
   int unsigned       pos_row    = 0;
   logic [PAIR_W-1:0] held_pair  = '0;
   logic [PAIR_W-1:0] row_pairs [STORE_DEPTH];   // never read before written

   rsp_type   avg_queue [$];   // averaged pixels still owed by the block
   stim_row_t dir_rows [$];

   int error_count   = 0;
   int requests_sent = 0;
   int results_seen  = 0;
   int level_setups  = 0;

   mip_box_downsample u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // Zero means 1, anything past the limit is clamped.
   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v,
                                           input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   // Append one expected averaged pixel to the owed list.
   function automatic void owe_result(input rsp_type r);
      avg_queue.insert(avg_queue.size(), r);
   endfunction

   // Append one line to the directed table.
   function automatic void add_row(input stim_row_t r);
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   // Box-average predictor for one accepted source pixel. Returns 1 when the
   // pixel completes an output block, with the averaged pixel in avg.
   function automatic bit box_average_step(input req_type px, output rsp_type avg);
      int unsigned       w, h, wd, hd, xo, yo, shift, n_act, i;
      logic [PAIR_W-1:0] pix, hpair, prev;
      logic [SUM_W+1:0]  total;
      logic [CHAN_W-1:0] lane_avg [LANES];
      bit                have_pair, emit;

      w  = eff_dim(cfg_width, MAX_SOURCE_WIDTH_DEF);
      h  = eff_dim(cfg_height, HEIGHT_LIMIT);
      wd = (w > 1) ? w / 2 : 1;
      hd = (h > 1) ? h / 2 : 1;
      case (cfg_mode)
         MODE_FOUR: n_act = 4;
         MODE_TWO:  n_act = 2;
         default:   n_act = 1;   // one channel, spare code too
      endcase

      // inactive channels never enter the lanes
      pix = '0;
      pix[0 +: SUM_W] = {1'b0, px.chan_a};
      if (n_act > 1) pix[SUM_W +: SUM_W] = {1'b0, px.chan_b};
      if (n_act > 2) begin
         pix[2*SUM_W +: SUM_W] = {1'b0, px.chan_c};
         pix[3*SUM_W +: SUM_W] = {1'b0, px.chan_d};
      end

      hpair     = '0;
      prev      = '0;
      have_pair = 1'b0;
      emit      = 1'b0;
      avg       = '0;

      // horizontal pairing; a dropped odd column falls through
      if (w == 1) begin
         hpair     = pix;
         have_pair = 1'b1;
      end else if (pos_col < 2 * wd) begin
         if (pos_col % 2 == 0) begin
            held_pair = pix;
         end else begin
            for (i = 0; i < LANES; i++)
               hpair[i*SUM_W +: SUM_W] = held_pair[i*SUM_W +: SUM_W] + pix[i*SUM_W +: SUM_W];
            have_pair = 1'b1;
         end
      end

      // vertical pairing; a dropped odd row falls through
      if (have_pair && pos_row < 2 * hd) begin
         xo    = (w == 1) ? 0 : pos_col / 2;
         yo    = (h == 1) ? 0 : pos_row / 2;
         shift = ((w > 1) ? 1 : 0) + ((h > 1) ? 1 : 0);
         if (h == 1) begin
            emit = 1'b1;
         end else if (pos_row % 2 == 0) begin
            row_pairs[xo] = hpair;
         end else begin
            prev = row_pairs[xo];
            emit = 1'b1;
         end
         if (emit) begin
            for (i = 0; i < LANES; i++) begin
               total       = prev[i*SUM_W +: SUM_W] + hpair[i*SUM_W +: SUM_W];
               lane_avg[i] = (i < n_act) ? CHAN_W'(total >> shift) : '0;
            end
            avg.avg_a      = lane_avg[0];
            avg.avg_b      = lane_avg[1];
            avg.avg_c      = lane_avg[2];
            avg.avg_d      = lane_avg[3];
            avg.level_done = (xo == wd - 1) && (yo == hd - 1);
         end
      end

      // advance, wrapping to the top-left after the last source pixel
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
      end else begin
         pos_col = pos_col + 1;
      end
      return emit;
   endfunction

   function automatic stim_row_t csr_row(input logic [CSR_IDX_W-1:0] idx,
                                         input logic [DIM_W-1:0] value);
      stim_row_t r;
      r           = '0;
      r.kind      = ROW_CSR;
      r.csr_idx   = idx;
      r.csr_value = value;
      return r;
   endfunction

   function automatic stim_row_t pixel_row(input req_type px);
      stim_row_t r;
      r      = '0;
      r.kind = ROW_PIXEL;
      r.px   = px;
      return r;
   endfunction

   function automatic stim_row_t known_row(input req_type px, input rsp_type result);
      stim_row_t r;
      r        = pixel_row(px);
      r.given  = 1'b1;
      r.result = result;
      return r;
   endfunction

   // Channel bytes lean on the extremes now and then.
   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   // Mostly tiny dimensions, sometimes zero, sometimes a few dozen.
   function automatic logic [DIM_W-1:0] rand_dim();
      case ($urandom_range(19))
         0:       return '0;
         1:       return DIM_W'($urandom_range(10, 48));
         default: return DIM_W'($urandom_range(1, 8));
      endcase
   endfunction

   // Offer one request, idling first at the sender's rate. Valid stays up
   // after acceptance so back-to-back requests never drop it.
   task automatic send_pixel(input req_type px, input bit given, input rsp_type known);
      rsp_type avg;
      bit      made;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      made = box_average_step(px, avg);
      if (given) owe_result(known);
      else if (made) owe_result(avg);
      requests_sent++;
   endtask

   task automatic send_run(input int unsigned count);
      req_type px;
      repeat (count) begin
         px.chan_a = rand_chan();
         px.chan_b = rand_chan();
         px.chan_c = rand_chan();
         px.chan_d = rand_chan();
         send_pixel(px, 1'b0, '0);
      end
   endtask

   // Stop sending, wait for every owed result, then let dropped pixels that
   // owe nothing clear the pipeline.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (avg_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      bit restart;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      restart = 1'b1;
      case (idx)
         CSR_WIDTH:  cfg_width  = value;
         CSR_HEIGHT: cfg_height = value;
         CSR_MODE:   cfg_mode   = value[1:0];
         default:    restart    = 1'b0;   // spare index: no effect at all
      endcase
      if (restart) begin
         pos_col   = 0;
         pos_row   = 0;
         held_pair = '0;
      end
      @(posedge clock);
   endtask

   task automatic start_level(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [1:0] mode);
      settle_block();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_MODE, DIM_W'(mode));
      level_setups++;
   endtask

   // Whole levels with random content, sometimes cut short by the next setup
   // or by the request budget of the phase.
   task automatic random_phase(input int unsigned stop_at);
      logic [DIM_W-1:0] w, h;
      int unsigned      level_px, run_len;
      w = rand_dim();
      h = rand_dim();
      start_level(w, h, 2'($urandom_range(3)));
      level_px = eff_dim(w, MAX_SOURCE_WIDTH_DEF) * eff_dim(h, HEIGHT_LIMIT);
      run_len  = $urandom_range(1, 3) * level_px;
      if ($urandom_range(4) == 0) run_len += $urandom_range(1, level_px);
      if (requests_sent + run_len > stop_at) run_len = stop_at - requests_sent;
      send_run(run_len);
   endtask

   // Receiver: random stall at its current rate, or a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_kick != hold_ack) begin
         hold_ack  <= hold_kick;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (avg_queue.size() == 0) begin
            $error("result with nothing pending: %h", rsp_data);
            error_count++;
         end else begin
            want = avg_queue.pop_front();
            if (rsp_data.avg_a !== want.avg_a) begin
               $error("avg_a: expected %0h, got %0h", want.avg_a, rsp_data.avg_a);
               error_count++;
            end
            if (rsp_data.avg_b !== want.avg_b) begin
               $error("avg_b: expected %0h, got %0h", want.avg_b, rsp_data.avg_b);
               error_count++;
            end
            if (rsp_data.avg_c !== want.avg_c) begin
               $error("avg_c: expected %0h, got %0h", want.avg_c, rsp_data.avg_c);
               error_count++;
            end
            if (rsp_data.avg_d !== want.avg_d) begin
               $error("avg_d: expected %0h, got %0h", want.avg_d, rsp_data.avg_d);
               error_count++;
            end
            if (rsp_data.level_done !== want.level_done) begin
               $error("level_done: expected %0b, got %0b",
                      want.level_done, rsp_data.level_done);
               error_count++;
            end
         end
      end
   end

   initial begin : run_sequence
      stim_row_t   row;
      int unsigned stop_at;

      // Directed table. After reset the level is 1x1, four channels, so each
      // request comes straight back with level_done set.
      add_row(known_row({8'hFF, 8'hFF, 8'hFF, 8'hFF},
                        {8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1}));
      add_row(known_row({8'h00, 8'h00, 8'h00, 8'h00},
                        {8'h00, 8'h00, 8'h00, 8'h00, 1'b1}));
      add_row(known_row({8'h12, 8'h34, 8'h56, 8'h78},
                        {8'h12, 8'h34, 8'h56, 8'h78, 1'b1}));
      // two-channel, one-channel and the spare mode zero the unused outputs
      add_row(csr_row(CSR_MODE, DIM_W'(MODE_TWO)));
      add_row(known_row({8'hAB, 8'hCD, 8'hEF, 8'h01},
                        {8'hAB, 8'hCD, 8'h00, 8'h00, 1'b1}));
      add_row(csr_row(CSR_MODE, DIM_W'(MODE_ONE)));
      add_row(known_row({8'hAB, 8'hCD, 8'hEF, 8'h01},
                        {8'hAB, 8'h00, 8'h00, 8'h00, 1'b1}));
      add_row(csr_row(CSR_MODE, DIM_W'(MODE_SPARE)));
      add_row(known_row({8'h5A, 8'hA5, 8'hC3, 8'h3C},
                        {8'h5A, 8'h00, 8'h00, 8'h00, 1'b1}));
      // 2x2 with a stray request, then a rewrite that restarts the level
      add_row(csr_row(CSR_MODE, DIM_W'(MODE_FOUR)));
      add_row(csr_row(CSR_WIDTH, 13'd2));
      add_row(csr_row(CSR_HEIGHT, 13'd2));
      add_row(pixel_row({8'h01, 8'h00, 8'hFF, 8'hFE}));
      add_row(csr_row(CSR_WIDTH, 13'd2));
      add_row(pixel_row({8'h01, 8'h00, 8'hFF, 8'hFE}));
      add_row(pixel_row({8'h02, 8'h01, 8'hFF, 8'hFF}));
      // spare register index: no effect, position must carry on
      add_row(csr_row(CSR_SPARE, 13'h1FFF));
      add_row(pixel_row({8'h02, 8'h01, 8'hFF, 8'hFF}));
      // 7/4, 3/4, 1019/4 truncate down
      add_row(known_row({8'h02, 8'h01, 8'hFE, 8'hFF},
                        {8'h01, 8'h00, 8'hFE, 8'hFE, 1'b1}));
      // 3x3: last column and row dropped, one result
      add_row(csr_row(CSR_WIDTH, 13'd3));
      add_row(csr_row(CSR_HEIGHT, 13'd3));
      add_row(pixel_row({8'h11, 8'h22, 8'h33, 8'h44}));
      add_row(pixel_row({8'h55, 8'h66, 8'h77, 8'h88}));
      add_row(pixel_row({8'h99, 8'hAA, 8'hBB, 8'hCC}));
      add_row(pixel_row({8'hDD, 8'hEE, 8'hFF, 8'h00}));
      add_row(pixel_row({8'hF0, 8'h0F, 8'h80, 8'h7F}));
      add_row(pixel_row({8'h01, 8'h02, 8'h03, 8'h04}));
      add_row(pixel_row({8'hFE, 8'hFD, 8'hFC, 8'hFB}));
      add_row(pixel_row({8'hC0, 8'h30, 8'h0C, 8'h03}));
      add_row(pixel_row({8'hAA, 8'h55, 8'hAA, 8'h55}));
      // zero dimensions act as 1: straight pass-through
      add_row(csr_row(CSR_WIDTH, 13'd0));
      add_row(csr_row(CSR_HEIGHT, 13'd0));
      add_row(known_row({8'h80, 8'h7F, 8'h01, 8'hFE},
                        {8'h80, 8'h7F, 8'h01, 8'hFE, 1'b1}));
      // one-wide column: vertical pair only
      add_row(csr_row(CSR_HEIGHT, 13'd2));
      add_row(pixel_row({8'hFF, 8'h01, 8'h80, 8'h00}));
      add_row(pixel_row({8'hFF, 8'h02, 8'h81, 8'h00}));
      // one-high row: horizontal pair only
      add_row(csr_row(CSR_WIDTH, 13'd2));
      add_row(csr_row(CSR_HEIGHT, 13'd1));
      add_row(pixel_row({8'h03, 8'hFF, 8'h00, 8'h7F}));
      add_row(pixel_row({8'h04, 8'hFE, 8'h01, 8'h80}));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            settle_block();
            write_csr(row.csr_idx, row.csr_value);
         end else begin
            send_pixel(row.px, row.given, row.result);
         end
      end

      // busy sender, slow receiver
      while (requests_sent < 550) random_phase(550);

      // slow sender, busy receiver
      send_idle_pct = 74;
      recv_idle_pct = 27;
      while (requests_sent < 1100) random_phase(1100);

      // no idling from here on
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Every request of a 1x1 level makes a result: hold the receiver off so
      // the block backs up and stalls requests, then pause the sender until
      // nothing is owed and pick up mid-stream.
      start_level(13'd1, 13'd1, MODE_FOUR);
      hold_kick <= ~hold_kick;
      send_run(120);
      req_valid <= 1'b0;
      @(posedge clock);
      while (avg_queue.size() != 0) @(posedge clock);
      send_run(80);

      // oversize width (clamped to 4096) along one row
      start_level(DIM_MAX, 13'd1, MODE_FOUR);
      send_run(150);
      // oversize height (clamped to 4096) down one column
      start_level(13'd1, DIM_MAX, MODE_TWO);
      send_run(150);

      stop_at = requests_sent + 350;
      while (requests_sent < stop_at) random_phase(stop_at);

      settle_block();
      $display("Covered %0d requests and %0d averaged pixels over %0d level setups,",
               requests_sent, results_seen, level_setups);
      $display("random small levels, oversize dimensions, every channel mode, long stalls.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/mbd_pkg.sv
rtl/mbd_pos.sv
rtl/mbd_lane.sv
rtl/mip_box_downsample.sv
sim/tb_mip_box_downsample.sv
